FILE: sv/wce_pkg.sv
package wce_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int MAX_COLUMNS   = 4096;
  localparam int SMP_CNT_BITS  = 32;
  localparam int COL_CNT_BITS  = 13;
  localparam int COL_IDX_BITS  = 12;
  localparam int PIX_BITS      = 16;
  localparam int Y_BITS        = 18;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 2;

  // divider iteration counter, natural column tracker, signed edge distance
  localparam int DIV_CNT_BITS  = $clog2(COL_CNT_BITS + 1);
  localparam int NAT_BITS      = COL_CNT_BITS + 1;
  localparam int DIFF_BITS     = SMP_CNT_BITS + 2;
  localparam int PROD_BITS     = SAMPLE_BITS + PIX_BITS + 1;
  localparam int ROUND_BIAS    = 1 << (SAMPLE_BITS - 2);

  localparam logic [SMP_CNT_BITS-1:0] RESET_SAMPLES = SMP_CNT_BITS'(4096);
  localparam logic [COL_CNT_BITS-1:0] RESET_COLUMNS = COL_CNT_BITS'(512);
  localparam logic [COL_CNT_BITS-1:0] COLUMNS_LIMIT = COL_CNT_BITS'(MAX_COLUMNS);

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SAMPLE_COUNT = 2'd0;
  localparam cfg_idx_t REG_COLUMN_COUNT = 2'd1;
  localparam cfg_idx_t REG_CENTER_Y     = 2'd2;
  localparam cfg_idx_t REG_HALF_HEIGHT  = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [Y_BITS-1:0]      ypix_t;

  localparam sample_t SAMPLE_POS_FULL = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_NEG_FULL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_START,
    ST_DIV,
    ST_INIT,
    ST_RUN
  } wce_state_e;

endpackage

FILE: sv/wce_sample_if.sv
interface wce_sample_if;
  import wce_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

FILE: sv/wce_column_if.sv
interface wce_column_if;
  import wce_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [COL_IDX_BITS-1:0] column_index;
  sample_t                 min_sample;
  sample_t                 max_sample;
  ypix_t                   y_of_max;
  ypix_t                   y_of_min;
  logic                    final_column;

  modport source (output valid, output column_index, output min_sample, output max_sample,
                  output y_of_max, output y_of_min, output final_column, input ready);
  modport sink   (input valid, input column_index, input min_sample, input max_sample,
                  input y_of_max, input y_of_min, input final_column, output ready);
endinterface

FILE: sv/wce_div.sv
module wce_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [wce_pkg::COL_CNT_BITS-1:0]  dividend_i,
  input  logic [wce_pkg::SMP_CNT_BITS-1:0]  divisor_i,
  output logic                              done_o,
  output logic [wce_pkg::COL_CNT_BITS-1:0]  quot_o,
  output logic [wce_pkg::COL_CNT_BITS-1:0]  rem_o
);
  import wce_pkg::*;

  // restoring division, one quotient bit per cycle
  logic                    busy_q, busy_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [COL_CNT_BITS-1:0] quo_q, quo_d;
  logic [COL_CNT_BITS-1:0] rem_q, rem_d;
  logic [COL_CNT_BITS:0]   trial;
  logic                    fits;

  assign trial = {rem_q, quo_q[COL_CNT_BITS-1]};
  assign fits  = SMP_CNT_BITS'(trial) >= divisor_i;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_BITS'(COL_CNT_BITS);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // divisor fits below the trial value, so its low bits are enough
      rem_d  = fits ? COL_CNT_BITS'(trial - divisor_i[COL_CNT_BITS:0])
                    : trial[COL_CNT_BITS-1:0];
      quo_d  = {quo_q[COL_CNT_BITS-2:0], fits};
      cnt_d  = cnt_q - DIV_CNT_BITS'(1);
      busy_d = (cnt_q != DIV_CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // last iteration runs this cycle; results settle at the next edge
  assign done_o = busy_q && (cnt_q == DIV_CNT_BITS'(1));
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: sv/waveform_column_envelope.sv
// Min/max column envelope of one sample stream, for a waveform display.
//
// Channels: sample_if takes one signed Q1.15 sample per request; column_if
// gives one request per closed column (index, min, max, both mapped to rows
// as center_y - v*half_height/2^15 in 1/16 pixel, and a last-column flag).
// Columns split sample_count samples into column_count columns; samples past
// the range start the next range. Columns that get no sample are skipped.
// Config: cfg_we_i/cfg_idx_i/cfg_data_i, to be written by the user only while
// the block idles; the block itself does not enforce this.
// Throughput: one sample per cycle while sample_if is ready. The sample that
// closes a column passes the column register, product register and output
// register before it is offered on column_if.
// Column tracking per sample is one 34-bit add/compare.
//
// Reset, and any write to sample_count or column_count, restarts the range
// and derives column_count / sample_count with a bit-serial divider: ready
// stays low through the start, 13 divide steps and the initial load.
// When the receiver stalls, the three result registers fill and ready drops
// only once all of them hold a column; samples that close no column are
// still taken while any of them is free.
module waveform_column_envelope (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  wce_pkg::cfg_idx_t                  cfg_idx_i,
  input  logic [wce_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  wce_sample_if.sink                         sample_if,
  wce_column_if.source                       column_if
);
  import wce_pkg::*;

  // ---------------------------------------------------------------- config
  logic [SMP_CNT_BITS-1:0] n_q;
  logic [COL_CNT_BITS-1:0] w_q;
  logic [PIX_BITS-1:0]     center_q;
  logic [PIX_BITS-1:0]     half_q;
  logic [COL_CNT_BITS-1:0] w_raw;
  logic                    restart;

  assign w_raw   = cfg_data_i[COL_CNT_BITS-1:0];
  assign restart = cfg_we_i && ((cfg_idx_i == REG_SAMPLE_COUNT) ||
                                (cfg_idx_i == REG_COLUMN_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= RESET_SAMPLES;
      w_q      <= RESET_COLUMNS;
      center_q <= '0;
      half_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SAMPLE_COUNT: begin
          // zero counts behave as one
          n_q <= (cfg_data_i == '0) ? SMP_CNT_BITS'(1) : cfg_data_i;
        end
        REG_COLUMN_COUNT: begin
          if (w_raw == '0) begin
            w_q <= COL_CNT_BITS'(1);
          end else if (w_raw > COLUMNS_LIMIT) begin
            w_q <= COLUMNS_LIMIT;
          end else begin
            w_q <= w_raw;
          end
        end
        REG_CENTER_Y:    center_q <= cfg_data_i[PIX_BITS-1:0];
        REG_HALF_HEIGHT: half_q   <= cfg_data_i[PIX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- control FSM
  wce_state_e              state_q, state_d;
  logic                    div_start, div_done, run, init_load;
  logic [COL_CNT_BITS-1:0] div_quot, div_rem;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_INIT;
      ST_INIT:  state_d = ST_RUN;
      ST_RUN:   state_d = ST_RUN;
      default:  state_d = ST_START;
    endcase
    if (restart) begin
      state_d = ST_START;
    end
  end

  always_comb begin
    div_start = 1'b0;
    init_load = 1'b0;
    run       = 1'b0;
    case (state_q)
      ST_START: div_start = 1'b1;
      ST_INIT:  init_load = 1'b1;
      ST_RUN:   run       = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
    end else begin
      state_q <= state_d;
    end
  end

  // column_count = quot * sample_count + rem
  wce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (w_q),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // ------------------------------------------------------ column tracking
  // S = (i+1)*W for the next sample i. d_q = (col+1)*N - S; the column
  // closes on a sample when W > d_q. n1_q is the column that S+W falls in,
  // ceil((S+W)/N)-1, and r1_q = (n1_q+1)*N - (S+W), kept in [0, N). Each
  // sample moves n1 by quot or quot+1, so a skip over empty columns is one
  // step with no divide.
  logic [COL_IDX_BITS-1:0]        col_q;
  logic signed [DIFF_BITS-1:0]    d_q;
  logic [NAT_BITS-1:0]            n1_q;
  logic [SMP_CNT_BITS-1:0]        r1_q;
  sample_t                        mn_q, mx_q;

  logic signed [DIFF_BITS-1:0]    d_init_q;
  logic [NAT_BITS-1:0]            n1_init_q;
  logic [SMP_CNT_BITS-1:0]        r1_init_q;

  logic [NAT_BITS-1:0]            rem2, quot2;
  logic signed [DIFF_BITS-1:0]    d_init;
  logic [NAT_BITS-1:0]            n1_init;
  logic [SMP_CNT_BITS-1:0]        r1_init;
  logic signed [DIFF_BITS-1:0]    w_ext;

  assign rem2   = {div_rem, 1'b0};
  assign quot2  = {div_quot, 1'b0};
  assign w_ext  = $signed({{(DIFF_BITS-COL_CNT_BITS){1'b0}}, w_q});
  assign d_init = $signed({2'b00, n_q}) - w_ext;

  // column holding S+W = 2W at range start
  always_comb begin
    if (rem2 == '0) begin
      n1_init = quot2 - NAT_BITS'(1);
      r1_init = '0;
    end else if (SMP_CNT_BITS'(rem2) <= n_q) begin
      n1_init = quot2;
      r1_init = n_q - SMP_CNT_BITS'(rem2);
    end else begin
      n1_init = quot2 + NAT_BITS'(1);
      r1_init = SMP_CNT_BITS'({n_q, 1'b0} - (SMP_CNT_BITS+1)'(rem2));
    end
  end

  logic                         acc, emit, last, cap;
  sample_t                      v, mn_new, mx_new;
  logic [COL_CNT_BITS-1:0]      wm1;
  logic [NAT_BITS-1:0]          n1_adv;
  logic [SMP_CNT_BITS-1:0]      r1_adv;
  logic [COL_IDX_BITS-1:0]      col_next;
  logic signed [DIFF_BITS-1:0]  d_emit;

  assign v      = sample_if.sample_value;
  assign acc    = sample_if.valid && sample_if.ready;
  assign mn_new = (v < mn_q) ? v : mn_q;
  assign mx_new = (v > mx_q) ? v : mx_q;
  assign emit   = w_ext > d_q;
  assign wm1    = w_q - COL_CNT_BITS'(1);
  assign last   = {1'b0, col_q} >= wm1;

  always_comb begin
    if (r1_q >= SMP_CNT_BITS'(div_rem)) begin
      n1_adv = n1_q + NAT_BITS'(div_quot);
      r1_adv = r1_q - SMP_CNT_BITS'(div_rem);
    end else begin
      n1_adv = n1_q + NAT_BITS'(div_quot) + NAT_BITS'(1);
      r1_adv = SMP_CNT_BITS'({1'b0, r1_q} + {1'b0, n_q} - (SMP_CNT_BITS+1)'(div_rem));
    end
  end

  // next column after a close; it can pass the last column only when the
  // range has a single sample (N = 1, r1 = 0), which the cap handles
  assign cap      = n1_q > {1'b0, wm1};
  assign col_next = cap ? wm1[COL_IDX_BITS-1:0] : n1_q[COL_IDX_BITS-1:0];
  assign d_emit   = cap ? $signed({2'b00, r1_q}) -
                          $signed(DIFF_BITS'(n1_q - {1'b0, wm1}))
                        : $signed({2'b00, r1_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      d_q       <= '0;
      n1_q      <= '0;
      r1_q      <= '0;
      mn_q      <= SAMPLE_POS_FULL;
      mx_q      <= SAMPLE_NEG_FULL;
      d_init_q  <= '0;
      n1_init_q <= '0;
      r1_init_q <= '0;
    end else if (init_load) begin
      col_q     <= '0;
      d_q       <= d_init;
      n1_q      <= n1_init;
      r1_q      <= r1_init;
      mn_q      <= SAMPLE_POS_FULL;
      mx_q      <= SAMPLE_NEG_FULL;
      d_init_q  <= d_init;
      n1_init_q <= n1_init;
      r1_init_q <= r1_init;
    end else if (acc) begin
      if (!emit) begin
        d_q  <= d_q - w_ext;
        n1_q <= n1_adv;
        r1_q <= r1_adv;
        mn_q <= mn_new;
        mx_q <= mx_new;
      end else if (last) begin
        col_q <= '0;
        d_q   <= d_init_q;
        n1_q  <= n1_init_q;
        r1_q  <= r1_init_q;
        mn_q  <= SAMPLE_POS_FULL;
        mx_q  <= SAMPLE_NEG_FULL;
      end else begin
        col_q <= col_next;
        d_q   <= d_emit;
        n1_q  <= n1_adv;
        r1_q  <= r1_adv;
        mn_q  <= SAMPLE_POS_FULL;
        mx_q  <= SAMPLE_NEG_FULL;
      end
    end
  end

  // -------------------------------------------------------- result pipe
  // A: closed column, B: products with half_height, C: output register
  logic a_v_q, b_v_q, c_v_q;
  logic a_free, b_free, c_free;

  assign c_free = !c_v_q || column_if.ready;
  assign b_free = !b_v_q || c_free;
  assign a_free = !a_v_q || b_free;

  assign sample_if.ready = run && a_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (a_free) a_v_q <= acc && emit;
      if (b_free) b_v_q <= a_v_q;
      if (c_free) c_v_q <= b_v_q;
    end
  end

  logic [COL_IDX_BITS-1:0]      a_col, b_col, c_col;
  sample_t                      a_min, a_max, b_min, b_max, c_min, c_max;
  logic                         a_last, b_last, c_last;
  logic signed [PROD_BITS-1:0]  b_pmax, b_pmin;
  ypix_t                        c_ymax, c_ymin;
  logic                         empty;

  // a column with no sample reports zeros
  assign empty = mn_new > mx_new;

  function automatic ypix_t map_y(logic signed [PROD_BITS-1:0] prod,
                                  logic [PIX_BITS-1:0] ctr);
    logic signed [PROD_BITS-1:0] biased;
    logic signed [Y_BITS:0]      quo;
    logic signed [Y_BITS:0]      y;
    // round to nearest, ties toward plus infinity
    biased = prod + PROD_BITS'(ROUND_BIAS);
    quo    = (Y_BITS+1)'(biased >>> (SAMPLE_BITS - 1));
    y      = $signed({{(Y_BITS+1-PIX_BITS){1'b0}}, ctr}) - quo;
    return y[Y_BITS-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (a_free && acc && emit) begin
      a_col  <= col_q;
      a_min  <= empty ? sample_t'(0) : mn_new;
      a_max  <= empty ? sample_t'(0) : mx_new;
      a_last <= last;
    end
    if (b_free && a_v_q) begin
      b_col  <= a_col;
      b_min  <= a_min;
      b_max  <= a_max;
      b_last <= a_last;
      b_pmax <= a_max * $signed({1'b0, half_q});
      b_pmin <= a_min * $signed({1'b0, half_q});
    end
    if (c_free && b_v_q) begin
      c_col  <= b_col;
      c_min  <= b_min;
      c_max  <= b_max;
      c_last <= b_last;
      c_ymax <= map_y(b_pmax, center_q);
      c_ymin <= map_y(b_pmin, center_q);
    end
  end

  assign column_if.valid        = c_v_q;
  assign column_if.column_index = c_col;
  assign column_if.min_sample   = c_min;
  assign column_if.max_sample   = c_max;
  assign column_if.y_of_max     = c_ymax;
  assign column_if.y_of_min     = c_ymin;
  assign column_if.final_column = c_last;

  // ----------------------------------------------------------- assertions
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ({1'b0, col_q} < w_q))
    else $error("current column beyond column count");

  a_rem_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (r1_q < n_q))
    else $error("edge remainder not below sample count");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (SMP_CNT_BITS'(div_rem) < n_q))
    else $error("divider remainder not below sample count");

  a_range_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && emit && last && !restart) |=> (col_q == '0))
    else $error("range did not restart after last column");

  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && emit) |=> (a_v_q && (a_last == ({1'b0, a_col} == w_q - COL_CNT_BITS'(1)))))
    else $error("last-column flag disagrees with column index");

endmodule

FILE: tb/tb_waveform_column_envelope.sv
module tb_waveform_column_envelope;
  timeunit 1ns;
  timeprecision 1ps;
  import wce_pkg::*;

  // Test sizing
  localparam int RANDOM_ITEMS = 1950;  // random samples after the directed table
  localparam int SETTLE       = 8;     // idle cycles before a register write (3 deep pipe)
  localparam int TAIL         = 12;    // idle cycles after the last column
  localparam int IDLE_LIMIT   = 3000;  // cycles with no request on either side
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off

  // One closed column, as the block reports it
  typedef struct packed {
    logic [COL_IDX_BITS-1:0] column_index;
    sample_t                 min_sample;
    sample_t                 max_sample;
    ypix_t                   y_of_max;
    ypix_t                   y_of_min;
    logic                    final_column;
  } column_t;

  // Directed table rows: a register write, a sample checked against the
  // envelope model, or a sample whose column is written out by hand.
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_SMP,
    ROW_COL
  } row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    cfg_idx_t                 idx;
    logic [CFG_DATA_BITS-1:0] data;
    sample_t                  smp;
    column_t                  col;
  } row_t;

  localparam column_t NO_COL = '0;
  localparam int DIR_ROWS = 27;

  localparam row_t DIR_TABLE [DIR_ROWS] = '{
    // reset setup: 4096 samples over 512 columns -> 8 samples per column, rows at 0
    '{ROW_SMP, REG_SAMPLE_COUNT, 32'd0, SAMPLE_POS_FULL, NO_COL},
    '{ROW_SMP, REG_SAMPLE_COUNT, 32'd0, SAMPLE_NEG_FULL, NO_COL},
    '{ROW_SMP, REG_SAMPLE_COUNT, 32'd0, 16'sd0, NO_COL},
    '{ROW_SMP, REG_SAMPLE_COUNT, 32'd0, -16'sd1, NO_COL},
    '{ROW_SMP, REG_SAMPLE_COUNT, 32'd0, 16'sd1, NO_COL},
    '{ROW_SMP, REG_SAMPLE_COUNT, 32'd0, sample_t'(16'h5555), NO_COL},
    '{ROW_SMP, REG_SAMPLE_COUNT, 32'd0, sample_t'(16'hAAAA), NO_COL},
    '{ROW_COL, REG_SAMPLE_COUNT, 32'd0, 16'sd100,
      '{12'd0, SAMPLE_NEG_FULL, SAMPLE_POS_FULL, 18'sd0, 18'sd0, 1'b0}},
    // two samples, one column; center = half = 2^15 so y = 32768 - v
    '{ROW_CFG, REG_SAMPLE_COUNT, 32'd2, 16'sd0, NO_COL},
    '{ROW_CFG, REG_COLUMN_COUNT, 32'd1, 16'sd0, NO_COL},
    '{ROW_CFG, REG_CENTER_Y,     32'd32768, 16'sd0, NO_COL},
    '{ROW_CFG, REG_HALF_HEIGHT,  32'd32768, 16'sd0, NO_COL},
    '{ROW_SMP, REG_SAMPLE_COUNT, 32'd0, SAMPLE_POS_FULL, NO_COL},
    '{ROW_COL, REG_SAMPLE_COUNT, 32'd0, SAMPLE_NEG_FULL,
      '{12'd0, SAMPLE_NEG_FULL, SAMPLE_POS_FULL, 18'sd1, 18'sd65536, 1'b1}},
    // mapping at full center and full height
    '{ROW_CFG, REG_CENTER_Y,     32'd65535, 16'sd0, NO_COL},
    '{ROW_CFG, REG_HALF_HEIGHT,  32'd65535, 16'sd0, NO_COL},
    '{ROW_SMP, REG_SAMPLE_COUNT, 32'd0, SAMPLE_NEG_FULL, NO_COL},
    '{ROW_SMP, REG_SAMPLE_COUNT, 32'd0, SAMPLE_POS_FULL, NO_COL},
    // zero counts act as one: every sample closes the last column
    '{ROW_CFG, REG_SAMPLE_COUNT, 32'd0, 16'sd0, NO_COL},
    '{ROW_CFG, REG_COLUMN_COUNT, 32'd0, 16'sd0, NO_COL},
    '{ROW_SMP, REG_SAMPLE_COUNT, 32'd0, -16'sd1, NO_COL},
    '{ROW_COL, REG_SAMPLE_COUNT, 32'd0, 16'sd0,
      '{12'd0, 16'sd0, 16'sd0, 18'sd65535, 18'sd65535, 1'b1}},
    // column count above the limit saturates; 3 samples over 4096 columns skip
    '{ROW_CFG, REG_SAMPLE_COUNT, 32'd3, 16'sd0, NO_COL},
    '{ROW_CFG, REG_COLUMN_COUNT, 32'd8191, 16'sd0, NO_COL},
    '{ROW_SMP, REG_SAMPLE_COUNT, 32'd0, 16'sd7, NO_COL},
    '{ROW_SMP, REG_SAMPLE_COUNT, 32'd0, -16'sd7, NO_COL},
    '{ROW_SMP, REG_SAMPLE_COUNT, 32'd0, 16'sd12345, NO_COL}
  };

  // Clock, reset, config port
  logic                     clk_i  = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i;
  cfg_idx_t                 cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  wce_sample_if sample_bus ();
  wce_column_if column_bus ();

  waveform_column_envelope u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_if  (sample_bus),
    .column_if  (column_bus)
  );

  // Envelope model: register copies and column tracking state
  logic [SMP_CNT_BITS-1:0] cfg_samples;
  logic [COL_CNT_BITS-1:0] cfg_columns;
  logic [PIX_BITS-1:0]     cfg_center;
  logic [PIX_BITS-1:0]     cfg_half;
  longint                  env_min;
  longint                  env_max;
  longint unsigned         env_col;
  longint unsigned         edge_smp;   // (i+1)*W for the next sample
  longint unsigned         edge_col;   // (x+1)*N for the open column

  column_t pending_cols [$];           // columns still owed by the block

  int  errors       = 0;
  int  samples_sent = 0;
  int  cols_seen    = 0;
  int  setups       = 0;
  int  holds        = 0;
  int  idle_cycles  = 0;
  bit  offering     = 1'b0;            // sample valid currently high
  int  burst_left   = 0;

  function automatic longint unsigned eff_samples();
    return (cfg_samples == '0) ? 64'd1 : 64'(cfg_samples);
  endfunction

  function automatic longint unsigned eff_columns();
    if (cfg_columns == '0) return 64'd1;
    if (cfg_columns > COLUMNS_LIMIT) return 64'(MAX_COLUMNS);
    return 64'(cfg_columns);
  endfunction

  function automatic void restart_range();
    env_min  = SAMPLE_POS_FULL;
    env_max  = SAMPLE_NEG_FULL;
    env_col  = 0;
    edge_smp = eff_columns();
    edge_col = eff_samples();
  endfunction

  // center - round(v * half / 2^15), ties up; >>> floors
  function automatic ypix_t row_of(longint v);
    longint h;
    longint q;
    h = cfg_half;
    q = (v * h + ROUND_BIAS) >>> (SAMPLE_BITS - 1);
    return ypix_t'(longint'(cfg_center) - q);
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_SAMPLE_COUNT: begin
        cfg_samples = data[SMP_CNT_BITS-1:0];
        restart_range();
      end
      REG_COLUMN_COUNT: begin
        cfg_columns = data[COL_CNT_BITS-1:0];
        restart_range();
      end
      REG_CENTER_Y:    cfg_center = data[PIX_BITS-1:0];
      REG_HALF_HEIGHT: cfg_half   = data[PIX_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Fold one sample into the open column; returns 1 when the column closes.
  function automatic bit envelope_step(sample_t s, output column_t col);
    longint          v;
    longint          mn;
    longint          mx;
    longint unsigned n;
    longint unsigned w;
    bit              last;
    v   = s;
    n   = eff_samples();
    w   = eff_columns();
    col = NO_COL;
    if (v < env_min) env_min = v;
    if (v > env_max) env_max = v;
    if (edge_smp + w <= edge_col) begin
      edge_smp += w;
      return 1'b0;
    end
    mn = env_min;
    mx = env_max;
    if (mn > mx) begin
      mn = 0;
      mx = 0;
    end
    last             = (env_col + 1 >= w);
    col.column_index = env_col[COL_IDX_BITS-1:0];
    col.min_sample   = sample_t'(mn);
    col.max_sample   = sample_t'(mx);
    col.y_of_max     = row_of(mx);
    col.y_of_min     = row_of(mn);
    col.final_column = last;
    if (last) begin
      restart_range();
    end else begin
      env_min   = SAMPLE_POS_FULL;
      env_max   = SAMPLE_NEG_FULL;
      edge_smp += w;
      env_col++;
      edge_col += n;
      // columns that get no sample are skipped
      while (edge_smp > edge_col && env_col + 1 < w) begin
        env_col++;
        edge_col += n;
      end
    end
    return 1'b1;
  endfunction

  // Register write: the enable is raised and left high, so back-to-back writes
  // need no second assignment in a step.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
  endtask

  // Drop valid, let every owed column drain, then let the pipe go quiet.
  task automatic settle_block();
    if (offering) begin
      sample_bus.valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_cols.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Offer one sample, wait for the request to be taken, record the expected
  // column (typed one if given), then pace the sender in bursts.
  task automatic send_sample(sample_t v, bit typed, column_t typed_col);
    column_t predicted;
    bit      closes;
    if (cfg_we_i) cfg_we_i <= 1'b0;
    sample_bus.valid        <= 1'b1;
    sample_bus.sample_value <= v;
    offering = 1'b1;
    do @(posedge clk_i); while (!sample_bus.ready);
    closes = envelope_step(v, predicted);
    if (typed) pending_cols.push_back(typed_col);
    else if (closes) pending_cols.push_back(predicted);
    samples_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      sample_bus.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      // mostly short bursts, now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 16);
    end
  endtask

  // One random setup: new registers, then a run of samples.
  task automatic random_phase();
    logic [CFG_DATA_BITS-1:0] data;
    longint unsigned          width;
    int                       count;
    int                       style;
    int                       amp;
    sample_t                  v;
    settle_block();
    setups++;
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 19))
        0:       data = '0;
        1:       data = '1;
        2:       data = $urandom();
        3, 4, 5: data = $urandom_range(1, 4096);
        default: data = $urandom_range(1, 64);
      endcase
      write_reg(REG_SAMPLE_COUNT, data);
    end
    if ($urandom_range(0, 3) != 0) begin
      data = $urandom();   // bits above the register are don't-care
      case ($urandom_range(0, 15))
        0:       data[COL_CNT_BITS-1:0] = '0;
        1:       data[COL_CNT_BITS-1:0] = COL_CNT_BITS'($urandom_range(MAX_COLUMNS + 1, 8191));
        2:       data[COL_CNT_BITS-1:0] = COLUMNS_LIMIT;
        3, 4:    data[COL_CNT_BITS-1:0] = COL_CNT_BITS'($urandom_range(1, MAX_COLUMNS));
        default: data[COL_CNT_BITS-1:0] = COL_CNT_BITS'($urandom_range(1, 16));
      endcase
      write_reg(REG_COLUMN_COUNT, data);
    end
    if ($urandom_range(0, 2) == 0) begin
      data = $urandom();
      case ($urandom_range(0, 3))
        0: data[PIX_BITS-1:0] = '0;
        1: data[PIX_BITS-1:0] = '1;
        default: ;
      endcase
      write_reg(REG_CENTER_Y, data);
    end
    if ($urandom_range(0, 2) == 0) begin
      data = $urandom();
      case ($urandom_range(0, 3))
        0: data[PIX_BITS-1:0] = '0;
        1: data[PIX_BITS-1:0] = '1;
        default: ;
      endcase
      write_reg(REG_HALF_HEIGHT, data);
    end
    // wide columns give no result for ages; keep those runs short
    width = eff_samples() / eff_columns();
    count = (width > 64) ? $urandom_range(8, 24) : $urandom_range(40, 200);
    style = $urandom_range(0, 3);
    amp   = $urandom_range(1, 2000);
    repeat (count) begin
      case (style)
        0: v = sample_t'($urandom());
        1: v = ($urandom_range(0, 1)) ? SAMPLE_POS_FULL : SAMPLE_NEG_FULL;
        2: v = sample_t'($urandom_range(0, 2 * amp) - amp);
        default: begin
          case ($urandom_range(0, 3))
            0:       v = SAMPLE_POS_FULL;
            1:       v = SAMPLE_NEG_FULL;
            default: v = sample_t'($urandom());
          endcase
        end
      endcase
      send_sample(v, 1'b0, NO_COL);
    end
  endtask

  // Column checker: every request out is matched against the oldest owed column.
  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    column_t want;
    if (rst_ni && column_bus.valid && column_bus.ready) begin
      if (pending_cols.size() == 0) begin
        $error("column %0d reported with none owed", column_bus.column_index);
        errors++;
      end else begin
        want = pending_cols.pop_front();
        check_field("column_index", want.column_index, column_bus.column_index);
        check_field("min_sample",   want.min_sample,   column_bus.min_sample);
        check_field("max_sample",   want.max_sample,   column_bus.max_sample);
        check_field("y_of_max",     want.y_of_max,     column_bus.y_of_max);
        check_field("y_of_min",     want.y_of_min,     column_bus.y_of_min);
        check_field("final_column", want.final_column, column_bus.final_column);
        cols_seen++;
      end
    end
  end

  // Receiver: ready follows a pattern whose mode is drawn anew for each random
  // span; twice in the run it holds off long enough to back up the input.
  initial begin
    int  mode;
    int  span;
    int  tick;
    column_bus.ready <= 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 4);
      span = $urandom_range(16, 200);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        case (mode)
          0, 1: column_bus.ready <= 1'b1;
          2:    column_bus.ready <= $urandom_range(0, 1);
          3:    column_bus.ready <= ($urandom_range(0, 3) == 0);
          default: column_bus.ready <= tick[2] & ~tick[4];
        endcase
      end
      if ((holds == 0 && samples_sent >= 700) || (holds == 1 && samples_sent >= 1500)) begin
        @(posedge clk_i);
        column_bus.ready <= 1'b0;
        holds++;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
    end
  end

  // Watchdog: too long without a request on either channel ends the run.
  always @(posedge clk_i) begin
    if ((sample_bus.valid && sample_bus.ready) || (column_bus.valid && column_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_waveform_column_envelope: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    row_t row;
    int   random_start;
    cfg_we_i                <= 1'b0;
    cfg_idx_i               <= REG_SAMPLE_COUNT;
    cfg_data_i              <= '0;
    sample_bus.valid        <= 1'b0;
    sample_bus.sample_value <= '0;
    cfg_samples = RESET_SAMPLES;
    cfg_columns = RESET_COLUMNS;
    cfg_center  = '0;
    cfg_half    = '0;
    restart_range();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table; a run of writes is preceded by one drain
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[i];
      if (row.kind == ROW_CFG) begin
        if (!cfg_we_i) begin
          settle_block();
          setups++;
        end
        write_reg(row.idx, row.data);
      end else begin
        send_sample(row.smp, row.kind == ROW_COL, row.col);
      end
    end

    random_start = samples_sent;
    while (samples_sent - random_start < RANDOM_ITEMS) random_phase();

    settle_block();
    repeat (TAIL) @(posedge clk_i);
    $display("covered %0d samples over %0d register setups, %0d columns compared,",
             samples_sent, setups, cols_seen);
    $display("with %0d long receiver hold-offs", holds);
    if (errors == 0 && pending_cols.size() == 0) begin
      $display("tb_waveform_column_envelope: done, clean");
    end else begin
      $display("tb_waveform_column_envelope: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/wce_pkg.sv
sv/wce_sample_if.sv
sv/wce_column_if.sv
sv/wce_div.sv
sv/waveform_column_envelope.sv
tb/tb_waveform_column_envelope.sv
